FILE: rtl/cascaded_biquad_filter_core_defines.svh
// Assertion helpers for the RTL file that carries checks.
// Both macros expect clk and rst_n in scope.
`ifndef CASCADED_BIQUAD_FILTER_CORE_DEFINES_SVH
`define CASCADED_BIQUAD_FILTER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CBQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbq_pkg.sv
package cbq_pkg;

    // Fixed field widths
    localparam int FIELD_W   = 24;
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 6;
    localparam int CFG_W     = 4;
    localparam int NTAPS     = 5;
    localparam int TAP_W     = 3;
    localparam int SLOT_W    = 4;
    localparam int ACC_GUARD = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_FILTER = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // Status that one cell reports to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } cell_stat_t;

    // Stage number of a coefficient slot: floor(idx / 5) as idx * 13 >> 6,
    // exact over the whole 6-bit range
    function automatic logic [SLOT_W-1:0] cbq_stage_of(input logic [IDX_W-1:0] idx);
        logic [9:0] prod;
        prod = 10'(idx) * 10'd13;
        return prod[9:6];
    endfunction

    // Tap number inside the stage: idx - 5 * stage
    function automatic logic [TAP_W-1:0] cbq_tap_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] base;
        base = IDX_W'(cbq_stage_of(idx)) * IDX_W'(NTAPS);
        return TAP_W'(idx - base);
    endfunction

endpackage

FILE: rtl/cbq_if.sv
interface cbq_in_if;
    import cbq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [FIELD_W-1:0]   sample_in;
    logic [IDX_W-1:0]            coef_index;
    logic signed [COEF_W-1:0]    coef_value;
    logic                        block_end;

    modport source (
        output valid, mode, sample_in, coef_index, coef_value, block_end,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_in, coef_index, coef_value, block_end,
        output ready
    );
endinterface

interface cbq_out_if;
    import cbq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [FIELD_W-1:0]   sample_out;
    logic                        block_end_out;

    modport source (
        output valid, sample_out, block_end_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out, block_end_out,
        output ready
    );
endinterface

FILE: rtl/cbq_cell.sv
module cbq_cell
    import cbq_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] v_in,
    input  logic                          clear,
    input  logic                          coef_we,
    input  logic [TAP_W-1:0]              coef_tap,
    input  logic signed [COEF_W-1:0]      coef_data,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output cell_stat_t                    stat
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + COEF_W;
    localparam int AW = PW + ACC_GUARD;
    localparam int QW = AW - COEF_FRAC;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(NTAPS - 1);
    localparam logic signed [AW-1:0] RND_HALF =
        {{(AW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

    logic signed [COEF_W-1:0] coef_reg [NTAPS];

    logic signed [SB-1:0] v_reg, x1_reg, x2_reg, y1_reg, y2_reg, y_reg;
    logic                 busy_reg;
    logic [TAP_W-1:0]     tap_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 pv_reg, pfirst_reg, plast_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 rnd_pend_reg;
    logic                 done_reg;

    logic signed [SB-1:0] op;
    logic signed [PW-1:0] prod_next;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] rnd;
    logic signed [QW-1:0] q;
    logic                 ovf;
    logic signed [SB-1:0] y_sat;

    // Store coefficient words
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_reg[coef_tap] <= coef_data;
        end
    end

    // Pick the history operand for the current tap
    always_comb
    begin
        case (tap_reg)
            3'd0:    op = v_reg;
            3'd1:    op = x1_reg;
            3'd2:    op = x2_reg;
            3'd3:    op = y1_reg;
            3'd4:    op = y2_reg;
            default: op = '0;
        endcase
        prod_next = op * coef_reg[tap_reg];
    end

    // Accumulate, then round half up and saturate
    always_comb
    begin
        acc_next = (pfirst_reg ? '0 : acc_reg) + AW'(prod_reg);
        rnd      = acc_reg + RND_HALF;
        q        = rnd[AW-1:COEF_FRAC];
        ovf      = (q[QW-1:SB-1] != {(QW-SB+1){q[QW-1]}});
        if (ovf)
        begin
            y_sat = {q[QW-1], {(SB-1){~q[QW-1]}}};
        end
        else
        begin
            y_sat = q[SB-1:0];
        end
    end

    // Step through the taps on the shared multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            tap_reg      <= '0;
            pv_reg       <= 1'b0;
            pfirst_reg   <= 1'b0;
            plast_reg    <= 1'b0;
            rnd_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pv_reg       <= busy_reg;
            pfirst_reg   <= (tap_reg == '0);
            plast_reg    <= (tap_reg == TAP_LAST);
            rnd_pend_reg <= pv_reg && plast_reg;
            done_reg     <= rnd_pend_reg;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                tap_reg  <= '0;
            end
            else if (busy_reg)
            begin
                tap_reg <= tap_reg + 1'b1;
                if (tap_reg == TAP_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Hold the stage input, products and the running sum
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            v_reg <= v_in;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
        if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
        if (rnd_pend_reg)
        begin
            y_reg <= y_sat;
        end
    end

    // Shift the history after each result; clear on request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (clear)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (rnd_pend_reg)
        begin
            x1_reg <= v_reg;
            x2_reg <= x1_reg;
            y1_reg <= y_sat;
            y2_reg <= y1_reg;
        end
    end

    assign y_out     = y_reg;
    assign stat.busy = busy_reg || pv_reg || rnd_pend_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/cascaded_biquad_filter_core.sv
// Cascade of direct-form-I biquad sections, fixed point.
// in_ch carries one item per handshake: mode 0 filters sample_in, mode 1
// writes coef_value into slot coef_index (stage * 5 + tap), mode 2 clears
// the history of every stage. Only mode 0 yields an item on out_ch, which
// carries the filtered sample and the block_end mark of its input item.
// cfg_we/cfg_data write the number of active stages (reset 1); values above
// the cell count act as the full chain, zero passes the input through.
// Each active stage is one cell with its own multiplier that walks its five
// taps in turn; a filter result passes through the active cells in order,
// if any, then into a pending register and from there into the output register.
// Loads and clears finish in the cycle they are accepted. One filter item
// is in work at a time; in_ch is ready again once its result sits in the
// output register, so a new item enters while out_ch is stalled. A second
// result waits inside until the output register frees up.
// Reset clears all history and sets the stage count to one; coefficients
// are undefined until written.
`include "cascaded_biquad_filter_core_defines.svh"

module cascaded_biquad_filter_core
    import cbq_pkg::*;
#(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    cbq_in_if.sink           in_ch,
    cbq_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int EW    = (SB > FIELD_W) ? SB : FIELD_W;
    localparam int NCOEF = MAX_STAGES * NTAPS;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     active_stages_reg;
    logic signed [SB-1:0] pend_reg;
    logic                 be_reg;
    logic signed [FIELD_W-1:0] out_data_reg;
    logic                 out_be_reg;
    logic                 out_valid_reg;

    logic accept;
    logic load_out;
    logic start0;
    logic bypass_acc;
    mode_t mode;

    logic [MAX_STAGES-1:0] active_vec;
    logic [MAX_STAGES-1:0] last_vec;
    logic [MAX_STAGES-1:0] done_vec;
    logic [MAX_STAGES-1:0] busy_vec;
    logic [MAX_STAGES-1:0] start_vec;
    cell_stat_t            cell_stat [MAX_STAGES];
    logic signed [SB-1:0]  cell_y [MAX_STAGES];

    logic signed [EW-1:0] sin_ext;
    logic                 sin_ovf;
    logic signed [SB-1:0] v0;
    logic                 fin_done;
    logic signed [SB-1:0] fin_y;
    logic signed [EW-1:0] pend_ext;

    logic                 coef_ok;
    logic [SLOT_W-1:0]    coef_stage;
    logic [TAP_W-1:0]     coef_tap;
    logic                 clear;

    assign mode   = mode_t'(in_ch.mode);
    assign accept = in_ch.valid && in_ch.ready;

    // Hold the stage-count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_stages_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            active_stages_reg <= cfg_data;
        end
    end

    // Mark active cells and the one that ends the chain
    always_comb
    begin
        for (int s = 0; s < MAX_STAGES; s++)
        begin
            active_vec[s] = ({1'b0, active_stages_reg} > (CFG_W+1)'(s));
        end
        for (int s = 0; s < MAX_STAGES; s++)
        begin
            if (s == MAX_STAGES - 1)
            begin
                last_vec[s] = active_vec[s];
            end
            else
            begin
                last_vec[s] = active_vec[s] && !active_vec[s+1];
            end
        end
    end

    // Saturate the incoming sample to the internal width
    always_comb
    begin
        sin_ext = EW'(in_ch.sample_in);
        sin_ovf = (sin_ext[EW-1:SB-1] != {(EW-SB+1){sin_ext[EW-1]}});
        if (sin_ovf)
        begin
            v0 = {sin_ext[EW-1], {(SB-1){~sin_ext[EW-1]}}};
        end
        else
        begin
            v0 = sin_ext[SB-1:0];
        end
    end

    // Decode coefficient writes and history clears
    assign coef_stage = cbq_stage_of(in_ch.coef_index);
    assign coef_tap   = cbq_tap_of(in_ch.coef_index);
    assign coef_ok    = accept && (mode == MODE_LOAD)
                        && ({1'b0, in_ch.coef_index} < (IDX_W+1)'(NCOEF));
    assign clear      = accept && (mode == MODE_CLEAR);

    // Chain of cells: each active cell starts when its neighbor finishes
    for (genvar s = 0; s < MAX_STAGES; s++)
    begin : g_cell
        if (s == 0)
        begin : g_head
            assign start_vec[s] = start0;
        end
        else
        begin : g_link
            assign start_vec[s] = done_vec[s-1] && active_vec[s];
        end

        cbq_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (start_vec[s]),
            .v_in      ((s == 0) ? v0 : cell_y[(s == 0) ? 0 : s-1]),
            .clear     (clear),
            .coef_we   (coef_ok && (coef_stage == SLOT_W'(s))),
            .coef_tap  (coef_tap),
            .coef_data (in_ch.coef_value),
            .y_out     (cell_y[s]),
            .stat      (cell_stat[s])
        );

        assign done_vec[s] = cell_stat[s].done;
        assign busy_vec[s] = cell_stat[s].busy;
    end

    // Take the result from the last active cell
    always_comb
    begin
        fin_done = |(done_vec & last_vec);
        fin_y    = '0;
        for (int s = 0; s < MAX_STAGES; s++)
        begin
            if (done_vec[s] && last_vec[s])
            begin
                fin_y = cell_y[s];
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_FILTER))
                begin
                    state_next = active_vec[0] ? ST_RUN : ST_HOLD;
                end
            end
            ST_RUN:
            begin
                if (fin_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        load_out    = 1'b0;
        start0      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                start0      = in_ch.valid && (mode == MODE_FILTER) && active_vec[0];
            end
            ST_HOLD:
            begin
                load_out = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the pending result and its block mark
    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_FILTER))
        begin
            be_reg   <= in_ch.block_end;
            pend_reg <= v0;
        end
        else if (fin_done && (state_reg == ST_RUN))
        begin
            pend_reg <= fin_y;
        end
    end

    // Output register
    assign pend_ext = EW'(pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= pend_ext[FIELD_W-1:0];
            out_be_reg   <= be_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sample_out    = out_data_reg;
    assign out_ch.block_end_out = out_be_reg;

    // Checks
    assign bypass_acc = accept && (mode == MODE_FILTER) && !active_vec[0];

    `CBQ_ASSERT_ALWAYS(a_idle_quiet, (state_reg != ST_IDLE) || ~|busy_vec, "cell busy while idle")
    `CBQ_ASSERT_ALWAYS(a_single_done, $onehot0(done_vec), "more than one cell finished at once")
    `CBQ_ASSERT_NEXT(a_bypass_hold, bypass_acc, state_reg == ST_HOLD, "pass-through item lost")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cbq_pkg::*;

    localparam int MAX_STAGES  = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int NHIST       = 4;
    localparam int NSLOTS      = MAX_STAGES * NTAPS;

    localparam logic [MODE_W-1:0]        MODE_UNUSED   = 2'd3;
    localparam logic [IDX_W-1:0]         IDX_TOP       = '1;
    localparam logic signed [FIELD_W-1:0] SAMPLE_TOP    = 24'sh7FFFFF;
    localparam logic signed [FIELD_W-1:0] SAMPLE_BOTTOM = 24'sh800000;
    localparam logic signed [COEF_W-1:0]  COEF_TOP      = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0]  COEF_BOTTOM   = 24'sh800000;
    localparam logic signed [COEF_W-1:0]  COEF_ONE      = 24'sh400000;
    localparam logic signed [COEF_W-1:0]  COEF_NEG_ONE  = 24'shC00000;
    localparam logic signed [COEF_W-1:0]  COEF_HALF     = 24'sh200000;
    localparam longint ACC_TOP    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint ACC_BOTTOM = -ACC_TOP - 1;

    localparam int DIRECTED_ROWS  = 26;
    localparam int RANDOM_ITEMS   = 600;
    localparam int PHASE_ITEMS    = 80;
    localparam int SETTLE_CYCLES  = 80;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_SPACING   = 150;
    localparam int TIMEOUT_CYCLES = 600_000;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [FIELD_W-1:0] sample;
        logic [IDX_W-1:0]          index;
        logic signed [COEF_W-1:0]  value;
        logic                      bend;
    } biquad_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sample;
        logic                      bend;
    } biquad_resp_t;

    typedef struct packed {
        biquad_req_t  req;
        logic         typed;
        biquad_resp_t want;
    } directed_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    cbq_in_if  in_ch ();
    cbq_out_if out_ch ();

    cascaded_biquad_filter_core #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Predicted filter state
    logic signed [COEF_W-1:0]  coef_mem [NSLOTS];
    logic signed [FIELD_W-1:0] hist_mem [MAX_STAGES * NHIST];
    logic [CFG_W-1:0]          stage_reg;

    biquad_resp_t expected_samples [$];
    biquad_resp_t front_want;
    int           mismatches = 0;
    int           items_sent = 0;
    int           cycle_count = 0;
    int           send_burst = 0;

    // Receiver pacing
    int recv_burst = 0;
    int stall_left = 0;
    int hold_left = 0;
    int results_taken = 0;
    int next_hold = 60;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic biquad_req_t make_req(input logic [MODE_W-1:0] mode,
                                             input logic signed [FIELD_W-1:0] sample,
                                             input logic [IDX_W-1:0] index,
                                             input logic signed [COEF_W-1:0] value,
                                             input logic bend);
        biquad_req_t req;
        req.mode   = mode;
        req.sample = sample;
        req.index  = index;
        req.value  = value;
        req.bend   = bend;
        return req;
    endfunction

    // Round half up at the Q2.22 point, then clamp to the sample range
    function automatic logic signed [FIELD_W-1:0] round_to_sample(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (q > ACC_TOP)
            q = ACC_TOP;
        if (q < ACC_BOTTOM)
            q = ACC_BOTTOM;
        return q[FIELD_W-1:0];
    endfunction

    // Advance the predicted state by one item; return 1 when it yields a sample
    function automatic bit cascade_step(input biquad_req_t req, output biquad_resp_t res);
        int active;
        int c;
        int h;
        longint acc;
        logic signed [FIELD_W-1:0] v;
        logic signed [FIELD_W-1:0] y;
        res = '0;
        cascade_step = 1'b0;
        case (req.mode)
            MODE_LOAD:
            begin
                if (int'(req.index) < NSLOTS)
                    coef_mem[req.index] = req.value;
            end
            MODE_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
            end
            MODE_FILTER:
            begin
                active = (stage_reg > CFG_W'(MAX_STAGES)) ? MAX_STAGES : int'(stage_reg);
                v = round_to_sample(longint'($signed(req.sample)) <<< COEF_FRAC);
                for (int s = 0; s < active; s++)
                begin
                    c = s * NTAPS;
                    h = s * NHIST;
                    acc = longint'(coef_mem[c])     * longint'(v)
                        + longint'(coef_mem[c + 1]) * longint'(hist_mem[h])
                        + longint'(coef_mem[c + 2]) * longint'(hist_mem[h + 1])
                        + longint'(coef_mem[c + 3]) * longint'(hist_mem[h + 2])
                        + longint'(coef_mem[c + 4]) * longint'(hist_mem[h + 3]);
                    y = round_to_sample(acc);
                    hist_mem[h + 1] = hist_mem[h];
                    hist_mem[h]     = v;
                    hist_mem[h + 3] = hist_mem[h + 2];
                    hist_mem[h + 2] = y;
                    v = y;
                end
                res.sample = v;
                res.bend   = req.bend;
                cascade_step = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int idle_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3)
        begin
            burst = int'($urandom_range(20, 80));
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_sample();
        int mild;
        mild = int'($urandom_range(0, 131071)) - 65536;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_TOP;
            1:       return SAMPLE_BOTTOM;
            2:       return '0;
            3, 4, 5: return FIELD_W'(mild);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Mostly small taps so the cascade stays in range, plus extremes
    function automatic logic signed [COEF_W-1:0] rand_coef();
        int mild;
        mild = int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return COEF_TOP;
            3:       return COEF_BOTTOM;
            4:       return COEF_W'($urandom);
            default: return COEF_W'(mild);
        endcase
    endfunction

    function automatic directed_row_t directed_row(input int i);
        directed_row_t row;
        row = '0;
        case (i)
            0:  row.req = make_req(MODE_CLEAR, '0, '0, '0, 1'b0);
            1:  row.req = make_req(MODE_LOAD, '0, 6'd0, COEF_ONE, 1'b0);
            2:  row.req = make_req(MODE_LOAD, '0, 6'd1, '0, 1'b0);
            3:  row.req = make_req(MODE_LOAD, '0, 6'd2, '0, 1'b0);
            4:  row.req = make_req(MODE_LOAD, '0, 6'd3, '0, 1'b0);
            5:  row.req = make_req(MODE_LOAD, '0, 6'd4, '0, 1'b0);
            6:  row = '{make_req(MODE_FILTER, SAMPLE_TOP, '0, '0, 1'b0), 1'b1,
                        '{SAMPLE_TOP, 1'b0}};
            7:  row = '{make_req(MODE_FILTER, SAMPLE_BOTTOM, '0, '0, 1'b1), 1'b1,
                        '{SAMPLE_BOTTOM, 1'b1}};
            8:  row = '{make_req(MODE_FILTER, '0, '0, '0, 1'b0), 1'b1, '{24'sd0, 1'b0}};
            9:  row = '{make_req(MODE_FILTER, 24'sd1, '0, '0, 1'b0), 1'b1, '{24'sd1, 1'b0}};
            10: row = '{make_req(MODE_FILTER, -24'sd1, '0, '0, 1'b0), 1'b1,
                        '{-24'sd1, 1'b0}};
            11: row.req = make_req(MODE_UNUSED, SAMPLE_TOP, IDX_TOP, COEF_TOP, 1'b1);
            12: row.req = make_req(MODE_LOAD, '0, IDX_TOP, COEF_TOP, 1'b1);
            13: row.req = make_req(MODE_LOAD, '0, IDX_W'(NSLOTS), 24'sh123456, 1'b0);
            14: row = '{make_req(MODE_FILTER, 24'sd12345, '0, '0, 1'b1), 1'b1,
                        '{24'sd12345, 1'b1}};
            15: row.req = make_req(MODE_LOAD, '0, 6'd0, COEF_NEG_ONE, 1'b0);
            16: row = '{make_req(MODE_FILTER, SAMPLE_BOTTOM, '0, '0, 1'b1), 1'b1,
                        '{SAMPLE_TOP, 1'b1}};
            17: row = '{make_req(MODE_FILTER, SAMPLE_TOP, '0, '0, 1'b0), 1'b1,
                        '{24'sh800001, 1'b0}};
            18: row.req = make_req(MODE_LOAD, '0, 6'd3, COEF_HALF, 1'b0);
            19: row.req = make_req(MODE_FILTER, 24'sh400000, '0, '0, 1'b0);
            20: row.req = make_req(MODE_FILTER, '0, '0, '0, 1'b1);
            21: row.req = make_req(MODE_LOAD, '0, 6'd1, COEF_TOP, 1'b0);
            22: row.req = make_req(MODE_LOAD, '0, 6'd0, COEF_BOTTOM, 1'b0);
            23: row.req = make_req(MODE_FILTER, SAMPLE_TOP, '0, '0, 1'b1);
            24: row.req = make_req(MODE_CLEAR, '0, '0, '0, 1'b1);
            default: row.req = make_req(MODE_FILTER, 24'sd100, '0, '0, 1'b0);
        endcase
        return row;
    endfunction

    // Offer one item after a random gap, predict it once it is taken
    task automatic send_request(input biquad_req_t req, input bit typed = 1'b0,
                                input biquad_resp_t want = '0);
        biquad_resp_t got;
        int gap;
        gap = idle_gap(send_burst);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= req.mode;
        in_ch.sample_in  <= req.sample;
        in_ch.coef_index <= req.index;
        in_ch.coef_value <= req.value;
        in_ch.block_end  <= req.bend;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (cascade_step(req, got))
            expected_samples.push_back(typed ? want : got);
        if (req.mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_request(make_req(MODE_UNUSED, FIELD_W'($urandom), IDX_W'($urandom),
                                     COEF_W'($urandom), 1'($urandom)));
            1: send_request(make_req(MODE_LOAD, FIELD_W'($urandom),
                                     IDX_W'($urandom_range(NSLOTS, int'(IDX_TOP))),
                                     COEF_W'($urandom), 1'($urandom)));
            2: send_request(make_req(MODE_LOAD, FIELD_W'($urandom),
                                     IDX_W'($urandom_range(0, NSLOTS - 1)),
                                     rand_coef(), 1'($urandom)));
            3: send_request(make_req(MODE_CLEAR, FIELD_W'($urandom), IDX_W'($urandom),
                                     COEF_W'($urandom), 1'($urandom)));
            default: send_request(make_req(MODE_FILTER, rand_sample(), IDX_W'($urandom),
                                           COEF_W'($urandom), 1'($urandom)));
        endcase
    endtask

    // Load every active stage, clear history, then filter one block, now and then with a noise item
    task automatic run_program();
        int active;
        int len;
        active = (stage_reg > CFG_W'(MAX_STAGES)) ? MAX_STAGES : int'(stage_reg);
        for (int s = 0; s < active; s++)
            for (int t = 0; t < NTAPS; t++)
                send_request(make_req(MODE_LOAD, FIELD_W'($urandom), IDX_W'(s * NTAPS + t),
                                      rand_coef(), 1'($urandom)));
        send_request(make_req(MODE_CLEAR, FIELD_W'($urandom), IDX_W'($urandom),
                              COEF_W'($urandom), 1'($urandom)));
        len = int'($urandom_range(3, 24));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send_request(make_req(MODE_FILTER, rand_sample(), IDX_W'($urandom),
                                  COEF_W'($urandom), 1'(i == len - 1)));
        end
    endtask

    // Drain the block, let it settle, then write the stage count
    task automatic write_stages(input logic [CFG_W-1:0] count);
        in_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        stage_reg = count;
    endtask

    // Stimulus
    initial
    begin
        directed_row_t row;
        int target;
        int phase;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_FILTER;
        in_ch.sample_in  <= '0;
        in_ch.coef_index <= '0;
        in_ch.coef_value <= '0;
        in_ch.block_end  <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= '0;
        rst_n            <= 1'b0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        stage_reg = CFG_W'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_row(i);
            send_request(row.req, row.typed, row.want);
        end

        target = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < target)
        begin
            case (phase)
                0:       write_stages(CFG_W'(MAX_STAGES));
                1:       write_stages('0);
                2:       write_stages('1);
                3:       write_stages(CFG_W'(3));
                4:       write_stages(CFG_W'(1));
                5:       write_stages(CFG_W'(MAX_STAGES + 1));
                default: write_stages(CFG_W'($urandom));
            endcase
            phase++;
            for (int n = items_sent + PHASE_ITEMS; items_sent < n; )
                run_program();
        end

        // Wait out the last results, then wait on to catch strays
        in_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Result side: random stalls plus a long hold every so often
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                results_taken++;
            if (hold_left == 0 && results_taken >= next_hold)
            begin
                hold_left = LONG_HOLD;
                next_hold += HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = idle_gap(recv_burst);
            end
        end
    end

    // Compare each taken item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected output item: sample_out %0d block_end_out %0b",
                       $signed(out_ch.sample_out), out_ch.block_end_out);
                mismatches++;
            end
            else
            begin
                front_want = expected_samples.pop_front();
                if (out_ch.sample_out !== front_want.sample)
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(front_want.sample), $signed(out_ch.sample_out));
                    mismatches++;
                end
                if (out_ch.block_end_out !== front_want.bend)
                begin
                    $error("block_end_out: expected %0b, actual %0b",
                           front_want.bend, out_ch.block_end_out);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule

FILE: cascaded_biquad_filter_core.f
+incdir+rtl
rtl/cbq_pkg.sv
rtl/cbq_if.sv
rtl/cbq_cell.sv
rtl/cascaded_biquad_filter_core.sv
verif/testbench.sv
